// ===== rtl/qjt_pkg.sv =====
// Shared types, constants and rounding helpers for the quaternion joint transform core.
// Stand-alone package; used by the core and by its port checker.
package qjt_pkg;

   localparam int QUAT_W     = 16;
   localparam int POS_W      = 32;
   localparam int SCALE_W    = 24;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register index, taken from paddr above the byte offset
   localparam logic [CSR_ADDR_W-3:0] REG_POSITION_SCALE = 1'b0;
   localparam logic [SCALE_W-1:0]    SCALE_RESET        = 24'd65536;

   // Internal widths
   localparam int QPROD_W = 2 * QUAT_W;            // quaternion product, Q.28
   localparam int Q28_W   = QPROD_W + 4;           // matrix entry before rounding
   localparam int SPROD_W = POS_W + SCALE_W + 1;   // scaled position, Q.32
   localparam int SPOS_W  = SPROD_W - 16;          // scaled position, Q.16
   localparam int RPROD_W = QUAT_W + SPOS_W;       // entry times scaled position, Q.30
   localparam int DIFF_W  = RPROD_W + 4;           // translation before rounding

   // 1.0 in Q.28 plus the rounding half of a 14-bit shift
   localparam logic signed [Q28_W-1:0] ROT_DIAG_BIAS = 36'sd268443648;
   localparam logic signed [Q28_W-1:0] ROT_HALF      = 36'sd8192;
   localparam logic signed [SPROD_W-1:0] POS_HALF    = 57'sd32768;
   localparam logic [13:0] TRANS_HALF_LSBS           = 14'h2000;

   typedef struct {
      logic signed [QPROD_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
      logic signed [SPROD_W-1:0] sb_prod [3];
      logic signed [SPROD_W-1:0] sp_prod [3];
   } s1_type;

   typedef struct {
      logic signed [QUAT_W-1:0] rot [9];
      logic signed [SPOS_W-1:0] sb  [3];
      logic signed [SPOS_W-1:0] sp  [3];
   } s2_type;

   typedef struct {
      logic signed [QUAT_W-1:0]  rot  [9];
      logic signed [RPROD_W-1:0] prod [9];
      logic signed [SPOS_W-1:0]  sp   [3];
   } s3_type;

   typedef struct {
      logic signed [QUAT_W-1:0] rot   [9];
      logic signed [POS_W-1:0]  trans [3];
   } s4_type;

   // Round a Q.28 entry to Q2.14, halves upwards, and clamp
   function automatic logic signed [QUAT_W-1:0] rot_round_sat(
      input logic signed [Q28_W-1:0] v);
      logic signed [Q28_W-1:0]    biased;
      logic signed [Q28_W-15:0]   shifted;
      logic signed [QUAT_W-1:0]   res;
      biased  = v + ROT_HALF;
      shifted = biased[Q28_W-1:14];
      if (shifted > 22'sd32767) begin
         res = 16'sh7FFF;
      end else if (shifted < -22'sd32768) begin
         res = 16'sh8000;
      end else begin
         res = shifted[QUAT_W-1:0];
      end
      return res;
   endfunction

   // Clamp an already rounded translation to the signed 32-bit range
   function automatic logic signed [POS_W-1:0] trans_sat(
      input logic signed [DIFF_W-15:0] v);
      logic signed [POS_W-1:0] res;
      if (v > 47'sd2147483647) begin
         res = 32'sh7FFF_FFFF;
      end else if (v < -47'sd2147483648) begin
         res = 32'sh8000_0000;
      end else begin
         res = v[POS_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/quaternion_joint_transform_core.sv =====
// Quaternion joint transform core: rotation matrix and translation per joint.
// Four-stage pipeline; depends on qjt_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   req     | in        | req_valid / req_stall  | quat_x..w Q2.14, bind/posed Q16.16
//   rsp     | out       | rsp_valid / rsp_stall  | rot_00..rot_22 Q2.14, trans Q16.16
//   csr     | in/out    | APB, pready tied high  | position_scale at byte address 0
//
// One joint per cycle sustained while rsp_stall is low; rsp_valid rises once the joint reaches the output register.
// Stages: quaternion and scale products, entry rounding, entry-by-position products,
// translation sum with rounding and clamp into the output register.
// Each stage holds only when it is full and the one after it cannot take its item,
// so bubbles close up and a stall at rsp backs up to req_stall without loss.
// Synchronous reset clears the valid bits and sets position_scale to 1.0.
module quaternion_joint_transform_core (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [qjt_pkg::QUAT_W-1:0]  req_quat_x,
   input  logic signed [qjt_pkg::QUAT_W-1:0]  req_quat_y,
   input  logic signed [qjt_pkg::QUAT_W-1:0]  req_quat_z,
   input  logic signed [qjt_pkg::QUAT_W-1:0]  req_quat_w,
   input  logic signed [qjt_pkg::POS_W-1:0]   req_bind_x,
   input  logic signed [qjt_pkg::POS_W-1:0]   req_bind_y,
   input  logic signed [qjt_pkg::POS_W-1:0]   req_bind_z,
   input  logic signed [qjt_pkg::POS_W-1:0]   req_posed_x,
   input  logic signed [qjt_pkg::POS_W-1:0]   req_posed_y,
   input  logic signed [qjt_pkg::POS_W-1:0]   req_posed_z,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [qjt_pkg::QUAT_W-1:0]  rsp_rot_00,
   output logic signed [qjt_pkg::QUAT_W-1:0]  rsp_rot_01,
   output logic signed [qjt_pkg::QUAT_W-1:0]  rsp_rot_02,
   output logic signed [qjt_pkg::QUAT_W-1:0]  rsp_rot_10,
   output logic signed [qjt_pkg::QUAT_W-1:0]  rsp_rot_11,
   output logic signed [qjt_pkg::QUAT_W-1:0]  rsp_rot_12,
   output logic signed [qjt_pkg::QUAT_W-1:0]  rsp_rot_20,
   output logic signed [qjt_pkg::QUAT_W-1:0]  rsp_rot_21,
   output logic signed [qjt_pkg::QUAT_W-1:0]  rsp_rot_22,
   output logic signed [qjt_pkg::POS_W-1:0]   rsp_trans_x,
   output logic signed [qjt_pkg::POS_W-1:0]   rsp_trans_y,
   output logic signed [qjt_pkg::POS_W-1:0]   rsp_trans_z,
   // configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [qjt_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [qjt_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [qjt_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   logic [qjt_pkg::SCALE_W-1:0] position_scale_ff, position_scale_in;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic load1, load2, load3, load4;

   qjt_pkg::s1_type s1_ff, s1_in;
   qjt_pkg::s2_type s2_ff, s2_in;
   qjt_pkg::s3_type s3_ff, s3_in;
   qjt_pkg::s4_type s4_ff, s4_in;

   logic signed [qjt_pkg::POS_W-1:0]   bind_pos  [3];
   logic signed [qjt_pkg::POS_W-1:0]   posed_pos [3];
   logic signed [qjt_pkg::SCALE_W:0]   scale_s;
   logic signed [qjt_pkg::Q28_W-1:0]   q28 [9];
   logic signed [qjt_pkg::SPROD_W-1:0] sb_rnd [3];
   logic signed [qjt_pkg::SPROD_W-1:0] sp_rnd [3];
   logic signed [qjt_pkg::DIFF_W-1:0]  diff [3];
   logic        csr_hit;

   // ---------------- configuration ----------------
   assign pready  = 1'b1;
   assign csr_hit = (paddr[qjt_pkg::CSR_ADDR_W-1:2] == qjt_pkg::REG_POSITION_SCALE);
   assign prdata  = csr_hit ? qjt_pkg::CSR_DATA_W'(position_scale_ff) : '0;

   always_comb begin
      position_scale_in = position_scale_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         position_scale_in = pwdata[qjt_pkg::SCALE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_scale_ff <= qjt_pkg::SCALE_RESET;
      end else begin
         position_scale_ff <= position_scale_in;
      end
   end

   // ---------------- flow control ----------------
   // A stage advances when empty or when the next stage advances
   assign load4     = !v4_ff || !rsp_stall;
   assign load3     = !v3_ff || load4;
   assign load2     = !v2_ff || load3;
   assign load1     = !v1_ff || load2;
   assign req_stall = !load1;

   assign v1_in = load1 ? req_valid : v1_ff;
   assign v2_in = load2 ? v1_ff     : v2_ff;
   assign v3_in = load3 ? v2_ff     : v3_ff;
   assign v4_in = load4 ? v3_ff     : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // ---------------- stage 1: products ----------------
   assign bind_pos[0]  = req_bind_x;
   assign bind_pos[1]  = req_bind_y;
   assign bind_pos[2]  = req_bind_z;
   assign posed_pos[0] = req_posed_x;
   assign posed_pos[1] = req_posed_y;
   assign posed_pos[2] = req_posed_z;
   assign scale_s      = $signed({1'b0, position_scale_ff});

   always_comb begin
      s1_in.xx = req_quat_x * req_quat_x;
      s1_in.yy = req_quat_y * req_quat_y;
      s1_in.zz = req_quat_z * req_quat_z;
      s1_in.xy = req_quat_x * req_quat_y;
      s1_in.xz = req_quat_x * req_quat_z;
      s1_in.yz = req_quat_y * req_quat_z;
      s1_in.wx = req_quat_w * req_quat_x;
      s1_in.wy = req_quat_w * req_quat_y;
      s1_in.wz = req_quat_w * req_quat_z;
      for (int i = 0; i < 3; i++) begin
         s1_in.sb_prod[i] = bind_pos[i]  * scale_s;
         s1_in.sp_prod[i] = posed_pos[i] * scale_s;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------- stage 2: matrix entries, scaled positions ----------------
   always_comb begin
      q28[0] = qjt_pkg::ROT_DIAG_BIAS - ((36'(s1_ff.yy) + 36'(s1_ff.zz)) <<< 1);
      q28[1] = (36'(s1_ff.xy) - 36'(s1_ff.wz)) <<< 1;
      q28[2] = (36'(s1_ff.xz) + 36'(s1_ff.wy)) <<< 1;
      q28[3] = (36'(s1_ff.xy) + 36'(s1_ff.wz)) <<< 1;
      q28[4] = qjt_pkg::ROT_DIAG_BIAS - ((36'(s1_ff.xx) + 36'(s1_ff.zz)) <<< 1);
      q28[5] = (36'(s1_ff.yz) - 36'(s1_ff.wx)) <<< 1;
      q28[6] = (36'(s1_ff.xz) - 36'(s1_ff.wy)) <<< 1;
      q28[7] = (36'(s1_ff.yz) + 36'(s1_ff.wx)) <<< 1;
      q28[8] = qjt_pkg::ROT_DIAG_BIAS - ((36'(s1_ff.xx) + 36'(s1_ff.yy)) <<< 1);
      for (int i = 0; i < 9; i++) begin
         // the diagonal bias already holds the rounding half, so strip it here
         if (i == 0 || i == 4 || i == 8) begin
            s2_in.rot[i] = qjt_pkg::rot_round_sat(q28[i] - qjt_pkg::ROT_HALF);
         end else begin
            s2_in.rot[i] = qjt_pkg::rot_round_sat(q28[i]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         sb_rnd[i]   = s1_ff.sb_prod[i] + qjt_pkg::POS_HALF;
         sp_rnd[i]   = s1_ff.sp_prod[i] + qjt_pkg::POS_HALF;
         s2_in.sb[i] = sb_rnd[i][qjt_pkg::SPROD_W-1:16];
         s2_in.sp[i] = sp_rnd[i][qjt_pkg::SPROD_W-1:16];
      end
   end

   always_ff @(posedge clock) begin
      if (load2) begin
         s2_ff <= s2_in;
      end
   end

   // ---------------- stage 3: R times scaled bind ----------------
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            s3_in.prod[r*3+c] = s2_ff.rot[r*3+c] * s2_ff.sb[c];
         end
      end
      s3_in.rot = s2_ff.rot;
      s3_in.sp  = s2_ff.sp;
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         s3_ff <= s3_in;
      end
   end

   // ---------------- stage 4: translation, output register ----------------
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         // posed term brought to Q.30 with the rounding half in its low bits
         diff[r] = qjt_pkg::DIFF_W'($signed({s3_ff.sp[r], qjt_pkg::TRANS_HALF_LSBS}))
                 - qjt_pkg::DIFF_W'(s3_ff.prod[r*3])
                 - qjt_pkg::DIFF_W'(s3_ff.prod[r*3+1])
                 - qjt_pkg::DIFF_W'(s3_ff.prod[r*3+2]);
         s4_in.trans[r] = qjt_pkg::trans_sat(diff[r][qjt_pkg::DIFF_W-1:14]);
      end
      s4_in.rot = s3_ff.rot;
   end

   always_ff @(posedge clock) begin
      if (load4) begin
         s4_ff <= s4_in;
      end
   end

   assign rsp_valid   = v4_ff;
   assign rsp_rot_00  = s4_ff.rot[0];
   assign rsp_rot_01  = s4_ff.rot[1];
   assign rsp_rot_02  = s4_ff.rot[2];
   assign rsp_rot_10  = s4_ff.rot[3];
   assign rsp_rot_11  = s4_ff.rot[4];
   assign rsp_rot_12  = s4_ff.rot[5];
   assign rsp_rot_20  = s4_ff.rot[6];
   assign rsp_rot_21  = s4_ff.rot[7];
   assign rsp_rot_22  = s4_ff.rot[8];
   assign rsp_trans_x = s4_ff.trans[0];
   assign rsp_trans_y = s4_ff.trans[1];
   assign rsp_trans_z = s4_ff.trans[2];

endmodule

// ===== rtl/qjt_checker.sv =====
// Port-level checks for the quaternion joint transform core, bound to the top level.
// Depends on qjt_pkg.
module qjt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [qjt_pkg::POS_W-1:0] rsp_trans_x,
   input logic                           psel,
   input logic                           penable,
   input logic                           pwrite,
   input logic [qjt_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [qjt_pkg::CSR_DATA_W-1:0] pwdata,
   input logic [qjt_pkg::CSR_DATA_W-1:0] prdata
);

   // Reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // Input backs up only when the output holds a result and is stalled
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with room in the pipeline");

   // A transfer shows at the output when nothing holds it on its way through the stages
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("result missing three free cycles after a transfer");

   // Held result stays valid and keeps its trans_x payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_trans_x))
      else $error("stalled result changed");

   // Scale register reads back what was written
   assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite &&
       paddr[qjt_pkg::CSR_ADDR_W-1:2] == qjt_pkg::REG_POSITION_SCALE)
      ##1 (paddr[qjt_pkg::CSR_ADDR_W-1:2] == qjt_pkg::REG_POSITION_SCALE)
      |-> prdata == {8'h00, $past(pwdata[qjt_pkg::SCALE_W-1:0])})
      else $error("position_scale read-back mismatch");

endmodule

bind quaternion_joint_transform_core qjt_checker u_qjt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_trans_x (rsp_trans_x),
   .psel        (psel),
   .penable     (penable),
   .pwrite      (pwrite),
   .paddr       (paddr),
   .pwdata      (pwdata),
   .prdata      (prdata)
);

// ===== verif/qjt_bench_pkg.sv =====
// Joint record, expected transform and scoreboard class for the joint transform bench.
// Depends on qjt_pkg for field widths and the reset value of the scale register.
package qjt_bench_pkg;

   typedef struct packed {
      logic [3:0][qjt_pkg::QUAT_W-1:0] quat;      // x, y, z, w
      logic [2:0][qjt_pkg::POS_W-1:0]  bind_pos;  // x, y, z
      logic [2:0][qjt_pkg::POS_W-1:0]  posed_pos; // x, y, z
   } joint_type;

   typedef struct packed {
      logic [8:0][qjt_pkg::QUAT_W-1:0] rot;       // row-major, entry 0 is row 0 column 0
      logic [2:0][qjt_pkg::POS_W-1:0]  trans;
   } xform_type;

   localparam longint ONE_Q28      = 64'sd1 << 28;
   localparam longint ROT_MAX      = 64'sd32767;
   localparam longint ROT_MIN      = -64'sd32768;
   localparam longint TRANS_MAX    = 64'sd2147483647;
   localparam longint TRANS_MIN    = -64'sd2147483648;
   localparam int     REPORT_LINES = 100;

   class joint_scoreboard;
      logic [qjt_pkg::SCALE_W-1:0] scale;
      xform_type                   expected_xforms[$];
      int                          mismatches;
      int                          results_seen;

      function new();
         scale        = qjt_pkg::SCALE_RESET;
         mismatches   = 0;
         results_seen = 0;
      endfunction

      // Drop n fraction bits, halves towards plus infinity
      static function longint round_off(longint v, int n);
         return (v + (64'sd1 << (n - 1))) >>> n;
      endfunction

      static function longint clamp(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function void set_scale(logic [qjt_pkg::SCALE_W-1:0] v);
         scale = v;
      endfunction

      function xform_type transform_of(joint_type j);
         xform_type res;
         longint x, y, z, w, s, acc, diff;
         longint q28 [9];
         longint r   [9];
         longint sb  [3];
         longint sp  [3];
         x = $signed(j.quat[0]);
         y = $signed(j.quat[1]);
         z = $signed(j.quat[2]);
         w = $signed(j.quat[3]);
         s = scale;
         q28[0] = ONE_Q28 - 2 * (y * y + z * z);
         q28[1] = 2 * (x * y - w * z);
         q28[2] = 2 * (x * z + w * y);
         q28[3] = 2 * (x * y + w * z);
         q28[4] = ONE_Q28 - 2 * (x * x + z * z);
         q28[5] = 2 * (y * z - w * x);
         q28[6] = 2 * (x * z - w * y);
         q28[7] = 2 * (y * z + w * x);
         q28[8] = ONE_Q28 - 2 * (x * x + y * y);
         for (int i = 0; i < 9; i++) begin
            r[i]       = clamp(round_off(q28[i], 14), ROT_MIN, ROT_MAX);
            res.rot[i] = r[i][qjt_pkg::QUAT_W-1:0];
         end
         // scaled positions stay at full width, no clamp
         for (int i = 0; i < 3; i++) begin
            sb[i] = round_off($signed(j.bind_pos[i]) * s, 16);
            sp[i] = round_off($signed(j.posed_pos[i]) * s, 16);
         end
         // the clamped entries feed the translation, same matrix as the output
         for (int i = 0; i < 3; i++) begin
            acc  = r[3 * i] * sb[0] + r[3 * i + 1] * sb[1] + r[3 * i + 2] * sb[2];
            diff = (sp[i] <<< 14) - acc;
            acc  = clamp(round_off(diff, 14), TRANS_MIN, TRANS_MAX);
            res.trans[i] = acc[qjt_pkg::POS_W-1:0];
         end
         return res;
      endfunction

      function void note_joint(joint_type j);
         expected_xforms.insert(expected_xforms.size(), transform_of(j));
      endfunction

      task report_mismatch(string msg);
         if (mismatches < REPORT_LINES) begin
            $display("MISMATCH %s", msg);
         end
         mismatches++;
      endtask

      task check_xform(xform_type got);
         xform_type want;
         string     diffs;
         results_seen++;
         if (expected_xforms.size() == 0) begin
            report_mismatch($sformatf("transform %0d arrived with no joint outstanding",
                                      results_seen));
            return;
         end
         want  = expected_xforms.pop_front();
         diffs = "";
         for (int i = 0; i < 9; i++) begin
            if (got.rot[i] !== want.rot[i]) begin
               diffs = {diffs, $sformatf(" rot_%0d%0d got %h want %h",
                                         i / 3, i % 3, got.rot[i], want.rot[i])};
            end
         end
         for (int i = 0; i < 3; i++) begin
            if (got.trans[i] !== want.trans[i]) begin
               diffs = {diffs, $sformatf(" trans_%s got %h want %h",
                                         (i == 0) ? "x" : ((i == 1) ? "y" : "z"),
                                         got.trans[i], want.trans[i])};
            end
         end
         if (diffs != "") begin
            report_mismatch($sformatf("transform %0d:%s", results_seen, diffs));
         end
      endtask
   endclass

endpackage

// ===== verif/quaternion_joint_transform_core_tb.sv =====
// Bench top for quaternion_joint_transform_core: drives joints and register writes,
// checks every transform against the scoreboard. Depends on qjt_pkg and qjt_bench_pkg.
module quaternion_joint_transform_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_DEPTH  = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int QUAT_ONE    = 16384;
   localparam int QUAT_HALF   = 8192;
   localparam int QUAT_MAX    = 32767;
   localparam int QUAT_MIN    = -32768;
   localparam int UNIT_SPAN   = 11585;   // about 1/sqrt(2) in Q2.14
   localparam int POS_ONE     = 65536;
   localparam int POS_MAX     = 32'sh7FFF_FFFF;
   localparam int POS_MIN     = 32'sh8000_0000;
   localparam logic [qjt_pkg::CSR_ADDR_W-3:0] REG_UNMAPPED = 1'b1;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [qjt_pkg::QUAT_W-1:0] req_quat_x, req_quat_y, req_quat_z, req_quat_w;
   logic signed [qjt_pkg::POS_W-1:0]  req_bind_x, req_bind_y, req_bind_z;
   logic signed [qjt_pkg::POS_W-1:0]  req_posed_x, req_posed_y, req_posed_z;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [qjt_pkg::QUAT_W-1:0] rsp_rot_00, rsp_rot_01, rsp_rot_02;
   logic signed [qjt_pkg::QUAT_W-1:0] rsp_rot_10, rsp_rot_11, rsp_rot_12;
   logic signed [qjt_pkg::QUAT_W-1:0] rsp_rot_20, rsp_rot_21, rsp_rot_22;
   logic signed [qjt_pkg::POS_W-1:0]  rsp_trans_x, rsp_trans_y, rsp_trans_z;
   logic psel, penable, pwrite;
   logic [qjt_pkg::CSR_ADDR_W-1:0] paddr;
   logic [qjt_pkg::CSR_DATA_W-1:0] pwdata;
   logic [qjt_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   qjt_bench_pkg::joint_scoreboard board;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int unsigned cycle_count   = 0;

   quaternion_joint_transform_core dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      qjt_bench_pkg::xform_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.rot   = {rsp_rot_22, rsp_rot_21, rsp_rot_20, rsp_rot_12, rsp_rot_11,
                       rsp_rot_10, rsp_rot_02, rsp_rot_01, rsp_rot_00};
         seen.trans = {rsp_trans_z, rsp_trans_y, rsp_trans_x};
         board.check_xform(seen);
      end
   end

   function automatic qjt_bench_pkg::joint_type make_joint(int qx, int qy, int qz, int qw,
                                                           int bx, int by, int bz,
                                                           int px, int py, int pz);
      qjt_bench_pkg::joint_type j;
      j.quat      = {qw[qjt_pkg::QUAT_W-1:0], qz[qjt_pkg::QUAT_W-1:0],
                     qy[qjt_pkg::QUAT_W-1:0], qx[qjt_pkg::QUAT_W-1:0]};
      j.bind_pos  = {bz, by, bx};
      j.posed_pos = {pz, py, px};
      return j;
   endfunction

   // Mostly near-unit quaternions, some full-range, some with one axis at an extreme
   function automatic qjt_bench_pkg::joint_type random_joint();
      qjt_bench_pkg::joint_type j;
      int kind, axis, v;
      kind = $urandom_range(9);
      axis = $urandom_range(3);
      for (int k = 0; k < 4; k++) begin
         if (kind >= 6 && kind < 8) begin
            v = $urandom;
         end else if (kind >= 8 && k == axis) begin
            v = $urandom_range(1) ? QUAT_MAX : QUAT_MIN;
         end else begin
            v = $urandom_range(2 * UNIT_SPAN);
            v = v - UNIT_SPAN;
         end
         j.quat[k] = v[qjt_pkg::QUAT_W-1:0];
      end
      for (int k = 0; k < 6; k++) begin
         v = $urandom;
         if ($urandom_range(3) != 0) begin
            v = v >>> $urandom_range(20, 4);
         end
         if (k < 3) begin
            j.bind_pos[k] = v;
         end else begin
            j.posed_pos[k - 3] = v;
         end
      end
      return j;
   endfunction

   // Called just after a falling edge; returns just after the falling edge that follows the transfer
   task automatic send_joint(input qjt_bench_pkg::joint_type j);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_quat_x  = j.quat[0];
      req_quat_y  = j.quat[1];
      req_quat_z  = j.quat[2];
      req_quat_w  = j.quat[3];
      req_bind_x  = j.bind_pos[0];
      req_bind_y  = j.bind_pos[1];
      req_bind_z  = j.bind_pos[2];
      req_posed_x = j.posed_pos[0];
      req_posed_y = j.posed_pos[1];
      req_posed_z = j.posed_pos[2];
      req_valid   = 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_joint(j);
      @(negedge clock);
   endtask

   task automatic run_random(input int count);
      repeat (count) send_joint(random_joint());
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (board.expected_xforms.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [qjt_pkg::CSR_ADDR_W-3:0] idx,
                            input logic [31:0] data);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == qjt_pkg::REG_POSITION_SCALE) begin
         board.set_scale(data[qjt_pkg::SCALE_W-1:0]);
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic csr_check_scale();
      logic [qjt_pkg::CSR_DATA_W-1:0] want;
      want    = qjt_pkg::CSR_DATA_W'(board.scale);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = {qjt_pkg::REG_POSITION_SCALE, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         board.report_mismatch($sformatf("position_scale read %h want %h", prdata, want));
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic run_directed();
      send_joint(make_joint(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_joint(make_joint(0, 0, 0, QUAT_ONE, POS_ONE, 2 * POS_ONE, -3 * POS_ONE,
                            POS_ONE / 2, -POS_ONE, 1));
      send_joint(make_joint(QUAT_MAX, 0, 0, 0, POS_MAX, POS_MIN, POS_MAX, 0, 0, 0));
      send_joint(make_joint(0, 0, 0, QUAT_MIN, 1, -1, POS_MIN, POS_MAX, 0, -1));
      send_joint(make_joint(QUAT_MAX, QUAT_MAX, QUAT_MAX, QUAT_MAX,
                            POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX));
      send_joint(make_joint(QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN,
                            POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN));
      send_joint(make_joint(QUAT_MAX, QUAT_MAX, QUAT_MIN, QUAT_MIN,
                            12345, -6789, 1000000, -5, 7, 9));
      send_joint(make_joint(QUAT_MIN, QUAT_MAX, QUAT_MAX, QUAT_MIN,
                            -POS_ONE, POS_ONE, 77, 3, -3, POS_MAX));
      send_joint(make_joint(QUAT_ONE, 0, 0, 0, POS_ONE, POS_ONE, POS_ONE, 0, 0, 0));
      send_joint(make_joint(0, QUAT_ONE, 0, 0, POS_ONE, -POS_ONE, POS_ONE, 1, 1, 1));
      send_joint(make_joint(0, 0, QUAT_ONE, 0, -POS_ONE, POS_ONE, 5 * POS_ONE, 0, 0, 0));
      send_joint(make_joint(QUAT_HALF, QUAT_HALF, QUAT_HALF, QUAT_HALF,
                            POS_ONE, 2 * POS_ONE, 3 * POS_ONE, -POS_ONE, 0, POS_ONE));
      // rotation entries landing exactly on a half, both signs
      send_joint(make_joint(64, 64, 0, 0, 0, 0, 0, 0, 0, 0));
      send_joint(make_joint(64, -64, 0, 0, 0, 0, 0, 0, 0, 0));
      // translation clamps at both ends
      send_joint(make_joint(0, 0, 0, QUAT_ONE, POS_MIN, 0, 0, POS_MAX, 0, 0));
      send_joint(make_joint(0, 0, 0, QUAT_ONE, POS_MAX, 0, 0, POS_MIN, 0, 0));
      // tiny r00 times an offset puts the translation exactly on a half
      send_joint(make_joint(0, UNIT_SPAN, 0, 0, -QUAT_HALF, 0, 0, 0, 0, 0));
      send_joint(make_joint(0, UNIT_SPAN, 0, 0, QUAT_HALF, 0, 0, 0, 0, 0));
      send_joint(make_joint(0, 0, 0, QUAT_ONE, 0, 0, 0, POS_MAX, POS_MIN, -1));
      send_joint(make_joint(0, 0, 0, -QUAT_ONE, -7, 11, POS_ONE, 13, -17, 19));
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_quat_x  = '0;
      req_quat_y  = '0;
      req_quat_z  = '0;
      req_quat_w  = '0;
      req_bind_x  = '0;
      req_bind_y  = '0;
      req_bind_z  = '0;
      req_posed_x = '0;
      req_posed_y = '0;
      req_posed_z = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      board       = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 37;
      recv_idle_pct = 82;
      run_directed();
      run_random(80);
      drain();
      // a write to an unmapped index must leave the scale alone
      csr_write(REG_UNMAPPED, 32'h00AB_CDEF);
      csr_check_scale();
      csr_write(qjt_pkg::REG_POSITION_SCALE, 32'h0000_8000);
      csr_check_scale();
      // scaled positions landing on a half, both signs
      send_joint(make_joint(0, 0, 0, QUAT_ONE, 1, -1, 3, 1, -1, -3));
      run_random(60);
      drain();

      send_idle_pct = 82;
      recv_idle_pct = 37;
      csr_write(qjt_pkg::REG_POSITION_SCALE, 32'hFFFF_FFFF);
      csr_check_scale();
      run_random(90);
      drain();
      csr_write(qjt_pkg::REG_POSITION_SCALE, 32'h0000_0000);
      csr_check_scale();
      run_random(40);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(qjt_pkg::REG_POSITION_SCALE, 32'h5A01_2345);
      csr_check_scale();
      run_random(90);
      drain();
      csr_write(qjt_pkg::REG_POSITION_SCALE, $urandom);
      csr_check_scale();
      run_random(90);
      drain();

      if (board.expected_xforms.size() != 0) begin
         board.report_mismatch("joints left without a transform");
      end
      if (board.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
